>>> rtl/agd_pkg.sv
package agd_pkg;

   localparam int RoundKeySlotsDefault = 15;
   localparam int BlockBits = 128;

   typedef enum logic [1:0] {
      REQ_LOAD_KEY  = 2'd0,
      REQ_LOAD_CTR  = 2'd1,
      REQ_LOAD_HASH = 2'd2,
      REQ_CIPHER    = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_KEY_MODE = 2'd0,
      CSR_HSUB_HI  = 2'd1,
      CSR_HSUB_LO  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ENG_IDLE  = 2'd0,
      ENG_FETCH = 2'd1,
      ENG_ROUND = 2'd2,
      ENG_DONE  = 2'd3
   } eng_state_type;

   // One classified word handed from the front end to the engine.
   typedef struct packed {
      logic [127:0] data;
      logic [127:0] counter;
      logic [4:0]   nbytes;
   } job_type;

   localparam int JobBits = $bits(job_type);

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
      };
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte k of a block sits at bits [127-8k -: 8].
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, all;
      logic [127:0] r;
      for (int i = 0; i < 16; i++) b[i] = s[127 - 8 * i -: 8];
      for (int c = 0; c < 4; c++)
         for (int w = 0; w < 4; w++)
            t[w + 4 * c] = sbox(b[w + 4 * ((c + w) % 4)]);
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[4 * c]     = a0 ^ all ^ xtime(a0 ^ a1);
            t[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
            t[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
            t[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = t[i];
      return r;
   endfunction

   // Mask with the first n bytes kept (n already clamped to 1..16).
   function automatic logic [127:0] byte_mask(input logic [4:0] n);
      logic [127:0] m;
      for (int i = 0; i < 16; i++) m[127 - 8 * i -: 8] = (5'(i) < n) ? 8'hff : 8'h00;
      return m;
   endfunction

endpackage

>>> rtl/agd_ram.sv
module agd_ram import agd_pkg::*; #(
   parameter int Width = 128,
   parameter int Depth = 15
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/agd_front.sv
module agd_front import agd_pkg::*; #(
   parameter int RoundKeySlots = RoundKeySlotsDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_type,
   input  logic [3:0]                       key_index,
   input  logic [63:0]                      word_hi,
   input  logic [63:0]                      word_lo,
   input  logic [4:0]                       byte_count,
   input  logic                             back_idle,
   output logic                             key_wr_en,
   output logic [$clog2(RoundKeySlots)-1:0] key_wr_addr,
   output logic [127:0]                     key_wr_data,
   output logic                             hash_ld_en,
   output logic [127:0]                     hash_ld_data,
   output logic                             job_valid,
   input  logic                             job_ready,
   output job_type                          job
);

   logic [127:0] ctr_ff, ctr_in;
   logic [4:0]   nb;
   logic         is_cipher, take, needs_idle;

   assign take      = req_valid && req_ready;
   assign is_cipher = req_kind_type'(req_type) == REQ_CIPHER && byte_count != 5'd0;
   assign nb        = (byte_count > 5'd16) ? 5'd16 : byte_count;
   // Key and hash loads wait until the back end holds no word, so that words already
   // queued still see the old key and hash; a ciphertext word waits for queue room.
   assign needs_idle = req_kind_type'(req_type) == REQ_LOAD_KEY
                       || req_kind_type'(req_type) == REQ_LOAD_HASH;
   assign req_ready = is_cipher ? job_ready : (!needs_idle || back_idle);
   assign job_valid = req_valid && is_cipher;
   assign job.data    = {word_hi, word_lo} & byte_mask(nb);
   assign job.counter = ctr_ff;
   assign job.nbytes  = nb;

   assign key_wr_en   = take && req_kind_type'(req_type) == REQ_LOAD_KEY
                        && 32'(key_index) < RoundKeySlots;
   assign key_wr_addr = key_index[$clog2(RoundKeySlots)-1:0];
   assign key_wr_data = {word_hi, word_lo};
   assign hash_ld_en  = take && req_kind_type'(req_type) == REQ_LOAD_HASH;
   assign hash_ld_data = {word_hi, word_lo};

   always_comb begin
      ctr_in = ctr_ff;
      if (take && req_kind_type'(req_type) == REQ_LOAD_CTR) ctr_in = {word_hi, word_lo};
      else if (take && is_cipher) ctr_in = {ctr_ff[127:32], ctr_ff[31:0] + 32'd1};
   end

   always_ff @(posedge clock) begin
      if (reset) ctr_ff <= '0;
      else ctr_ff <= ctr_in;
   end

endmodule

>>> rtl/agd_queue.sv
module agd_queue import agd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_ready,
   output job_type out_job
);

   job_type     slot_ff [2];
   logic [1:0]  count_ff, count_in;
   logic        rd_ff, wr_ff, push, pop;

   assign in_ready  = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_job   = slot_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= in_job;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("queue count out of range");

endmodule

>>> rtl/agd_engine.sv
module agd_engine import agd_pkg::*; #(
   parameter int RoundKeySlots = RoundKeySlotsDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [1:0]                       key_mode,
   input  logic [127:0]                     hsub,
   input  logic                             hash_ld_en,
   input  logic [127:0]                     hash_ld_data,
   input  logic                             job_valid,
   output logic                             job_ready,
   input  job_type                          job,
   output logic [$clog2(RoundKeySlots)-1:0] key_rd_addr,
   input  logic [127:0]                     key_rd_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [63:0]                      plain_hi,
   output logic [63:0]                      plain_lo,
   output logic [4:0]                       out_bytes,
   output logic [63:0]                      hash_hi,
   output logic [63:0]                      hash_lo
);

   localparam int KeyBits = $clog2(RoundKeySlots);
   localparam int GhStep  = 8;

   eng_state_type state_ff, state_in;
   logic [KeyBits-1:0] rnd_ff, rnd_in, last_rnd;
   logic [127:0] aes_ff, aes_in, data_ff, hacc_ff, hacc_in;
   logic [127:0] gx_ff, gv_ff, gz_ff, gv_in, gz_in;
   logic [4:0]   nb_ff;
   logic [3:0]   gcnt_ff;
   logic         gbusy_ff, start, out_free, fin;
   logic         rsp_valid_ff;
   logic [127:0] pt_ff, hout_ff;
   logic [4:0]   ob_ff;

   always_comb begin
      unique case (key_mode)
         2'd0:    last_rnd = (RoundKeySlots - 1 < 10) ? KeyBits'(RoundKeySlots - 1) : KeyBits'(10);
         2'd1:    last_rnd = (RoundKeySlots - 1 < 12) ? KeyBits'(RoundKeySlots - 1) : KeyBits'(12);
         default: last_rnd = (RoundKeySlots - 1 < 14) ? KeyBits'(RoundKeySlots - 1) : KeyBits'(14);
      endcase
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign job_ready = state_ff == ENG_IDLE;
   assign start     = job_valid && job_ready;
   assign key_rd_addr = (state_ff == ENG_IDLE) ? '0 : rnd_ff;
   assign fin = state_ff == ENG_DONE && !gbusy_ff && out_free;

   // GHASH: eight bits of X per cycle, overlapped with AES.
   always_comb begin
      gv_in = gv_ff;
      gz_in = gz_ff;
      for (int i = 0; i < GhStep; i++) begin
         if (gx_ff[127 - i]) gz_in = gz_in ^ gv_in;
         gv_in = {1'b0, gv_in[127:1]} ^ (gv_in[0] ? {8'he1, 120'd0} : 128'd0);
      end
   end

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      aes_in   = aes_ff;
      hacc_in  = hacc_ff;
      if (hash_ld_en) hacc_in = hash_ld_data;
      unique case (state_ff)
         ENG_IDLE: if (start) begin
            state_in = ENG_FETCH;
            rnd_in   = KeyBits'(1);
         end
         ENG_FETCH: begin
            aes_in   = aes_ff ^ key_rd_data;
            rnd_in   = rnd_ff + KeyBits'(1);
            state_in = ENG_ROUND;
         end
         ENG_ROUND: begin
            aes_in = aes_round(aes_ff, (rnd_ff - KeyBits'(1)) == last_rnd) ^ key_rd_data;
            if ((rnd_ff - KeyBits'(1)) == last_rnd) state_in = ENG_DONE;
            else rnd_in = rnd_ff + KeyBits'(1);
         end
         ENG_DONE: if (fin) begin
            state_in = ENG_IDLE;
            hacc_in  = gz_ff;
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ENG_IDLE;
         rnd_ff       <= '0;
         hacc_ff      <= '0;
         gbusy_ff     <= 1'b0;
         gcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         hacc_ff  <= hacc_in;
         if (start) begin
            gbusy_ff <= 1'b1;
            gcnt_ff  <= '0;
         end else if (gbusy_ff) begin
            gcnt_ff <= gcnt_ff + 4'd1;
            if (gcnt_ff == 4'd15) gbusy_ff <= 1'b0;
         end
         if (fin) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         aes_ff  <= job.counter;
         data_ff <= job.data;
         nb_ff   <= job.nbytes;
         gx_ff   <= hacc_ff ^ job.data;
         gv_ff   <= hsub;
         gz_ff   <= '0;
      end else begin
         aes_ff <= aes_in;
         if (gbusy_ff) begin
            gx_ff <= {gx_ff[127-GhStep:0], {GhStep{1'b0}}};
            gv_ff <= gv_in;
            gz_ff <= gz_in;
         end
      end
      if (fin) begin
         pt_ff   <= (data_ff ^ aes_ff) & byte_mask(nb_ff);
         ob_ff   <= nb_ff;
         hout_ff <= gz_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign plain_hi  = pt_ff[127:64];
   assign plain_lo  = pt_ff[63:0];
   assign out_bytes = ob_ff;
   assign hash_hi   = hout_ff[127:64];
   assign hash_lo   = hout_ff[63:0];

   a_fin_gh_done: assert property (@(posedge clock) disable iff (reset)
      fin |-> !gbusy_ff) else $error("result before GHASH finished");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff) else $error("result dropped");
   a_busy_start: assert property (@(posedge clock) disable iff (reset)
      start |=> state_ff == ENG_FETCH && gbusy_ff) else $error("engine did not start");

endmodule

>>> rtl/aes_gcm_decrypt_stream.sv
// A ciphertext word's plaintext is offered, for every key size, only after the GHASH multiply
// (eight bits per cycle) is done, since that multiply outlasts the 10..14 AES rounds.
// The engine takes one ciphertext word at a time (start, key fetch, GHASH steps and the
// result) and holds it while the result side stalls. Loads give no result; counter loads are
// taken every cycle, key and hash loads wait until no ciphertext word is queued or in flight.
// Reset (synchronous, active high) clears counter, hash, subkey, key mode and handshakes.
module aes_gcm_decrypt_stream import agd_pkg::*; #(
   parameter int RoundKeySlots = RoundKeySlotsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [3:0]  req_key_index,
   input  logic [63:0] req_word_hi,
   input  logic [63:0] req_word_lo,
   input  logic [4:0]  req_byte_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_plain_hi,
   output logic [63:0] rsp_plain_lo,
   output logic [4:0]  rsp_out_bytes,
   output logic [63:0] rsp_hash_hi,
   output logic [63:0] rsp_hash_lo
);

   localparam int KeyBits = $clog2(RoundKeySlots);

   // Configuration registers; a write is always taken at once.
   logic [1:0]   key_mode_ff;
   logic [127:0] hsub_ff;

   logic               key_wr_en, hash_ld_en;
   logic [KeyBits-1:0] key_wr_addr, key_rd_addr;
   logic [127:0]       key_wr_data, key_rd_data, hash_ld_data;
   logic               fq_valid, fq_ready, qe_valid, qe_ready;
   logic               back_idle;
   job_type            fq_job, qe_job;

   assign csr_ready = 1'b1;

   // The back end is idle when the queue is empty and the engine waits for a word.
   assign back_idle = !qe_valid && qe_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_mode_ff <= '0;
         hsub_ff     <= '0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_KEY_MODE: key_mode_ff <= csr_data[1:0];
            CSR_HSUB_HI:  hsub_ff[127:64] <= csr_data;
            CSR_HSUB_LO:  hsub_ff[63:0] <= csr_data;
            default: ;
         endcase
      end
   end

   // The front end applies loads and steps the counter, so each ciphertext word
   // carries its own counter value through the queue.
   agd_front #(.RoundKeySlots(RoundKeySlots)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_type,
      .key_index(req_key_index), .word_hi(req_word_hi), .word_lo(req_word_lo),
      .byte_count(req_byte_count), .back_idle,
      .key_wr_en, .key_wr_addr, .key_wr_data, .hash_ld_en, .hash_ld_data,
      .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
   );

   agd_queue u_queue (
      .clock, .reset, .in_valid(fq_valid), .in_ready(fq_ready), .in_job(fq_job),
      .out_valid(qe_valid), .out_ready(qe_ready), .out_job(qe_job)
   );

   agd_ram #(.Width(BlockBits), .Depth(RoundKeySlots)) u_keys (
      .clock, .wr_en(key_wr_en), .wr_addr(key_wr_addr), .wr_data(key_wr_data),
      .rd_addr(key_rd_addr), .rd_data(key_rd_data)
   );

   agd_engine #(.RoundKeySlots(RoundKeySlots)) u_engine (
      .clock, .reset, .key_mode(key_mode_ff), .hsub(hsub_ff),
      .hash_ld_en, .hash_ld_data,
      .job_valid(qe_valid), .job_ready(qe_ready), .job(qe_job),
      .key_rd_addr, .key_rd_data,
      .rsp_valid, .rsp_ready,
      .plain_hi(rsp_plain_hi), .plain_lo(rsp_plain_lo), .out_bytes(rsp_out_bytes),
      .hash_hi(rsp_hash_hi), .hash_lo(rsp_hash_lo)
   );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the AES-GCM decryption stream. An in-bench model of the
// datapath (AES rounds, GHASH multiply, counter increment) predicts each plaintext
// word, and a checker process compares every response against the oldest prediction.
module testbench;
   import agd_pkg::*;

   typedef struct {
      logic [63:0] plain_hi;
      logic [63:0] plain_lo;
      logic [4:0]  out_bytes;
      logic [63:0] hash_hi;
      logic [63:0] hash_lo;
   } plain_word_type;

   // The SubBytes table is kept locally so that the prediction shares no code with the block.
   localparam logic [7:0] SubTable [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = '0;
   logic [3:0]  req_key_index = '0;
   logic [63:0] req_word_hi = '0;
   logic [63:0] req_word_lo = '0;
   logic [4:0]  req_byte_count = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_plain_hi, rsp_plain_lo, rsp_hash_hi, rsp_hash_lo;
   logic [4:0]  rsp_out_bytes;

   // Shadow copies of the block's state and registers.
   logic [127:0] shadow_keys [RoundKeySlotsDefault];
   logic [127:0] shadow_counter;
   logic [127:0] shadow_hash;
   logic [127:0] shadow_subkey;
   logic [1:0]   shadow_mode;

   plain_word_type plain_pending [$];
   int mismatch_count = 0;
   bit rsp_stall_off = 1'b0;

   aes_gcm_decrypt_stream i_dut (.*);

   always #2 clock = ~clock;

   initial begin
      #50ms;
      $display("Regression FAIL");
      $finish;
   end

   // GF(2^128) multiply in GCM bit order; bit 127 of a vector is the first bit of byte 0.
   function automatic logic [127:0] ghash_mul(input logic [127:0] x, input logic [127:0] y);
      logic [127:0] v;
      logic [127:0] z;
      v = y;
      z = '0;
      for (int i = 0; i < 128; i++) begin
         if (x[127 - i]) z ^= v;
         v = v[0] ? ((v >> 1) ^ {8'he1, 120'd0}) : (v >> 1);
      end
      return z;
   endfunction

   function automatic logic [7:0] mul2(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [127:0] aes_keystream(input logic [127:0] blk);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, sum;
      logic [127:0] res;
      int rounds;
      rounds = (shadow_mode == 2'd0) ? 10 : (shadow_mode == 2'd1) ? 12 : 14;
      if (rounds > RoundKeySlotsDefault - 1) rounds = RoundKeySlotsDefault - 1;
      for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8] ^ shadow_keys[0][127 - 8 * i -: 8];
      for (int r = 1; r <= rounds; r++) begin
         for (int c = 0; c < 4; c++)
            for (int w = 0; w < 4; w++) t[w + 4 * c] = SubTable[s[w + 4 * ((c + w) % 4)]];
         if (r != rounds) begin
            for (int c = 0; c < 4; c++) begin
               a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
               sum = a0 ^ a1 ^ a2 ^ a3;
               t[4 * c]     = a0 ^ sum ^ mul2(a0 ^ a1);
               t[4 * c + 1] = a1 ^ sum ^ mul2(a1 ^ a2);
               t[4 * c + 2] = a2 ^ sum ^ mul2(a2 ^ a3);
               t[4 * c + 3] = a3 ^ sum ^ mul2(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) s[i] = t[i] ^ shadow_keys[r][127 - 8 * i -: 8];
      end
      for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
      return res;
   endfunction

   // Updates the shadow state for one accepted word and queues any plaintext it yields.
   function automatic void decrypt_word(input logic [1:0] kind, input logic [3:0] slot,
                                        input logic [127:0] data, input logic [4:0] count);
      logic [127:0] mask;
      logic [127:0] ct;
      logic [127:0] pt;
      int n;
      plain_word_type w;
      case (kind)
         REQ_LOAD_KEY: begin
            if (slot < RoundKeySlotsDefault) shadow_keys[slot] = data;
         end
         REQ_LOAD_CTR: shadow_counter = data;
         REQ_LOAD_HASH: shadow_hash = data;
         default: begin
            if (count != 0) begin
               n = (count > 16) ? 16 : count;
               for (int i = 0; i < 16; i++) mask[127 - 8 * i -: 8] = (i < n) ? 8'hff : 8'h00;
               ct = data & mask;
               shadow_hash = ghash_mul(shadow_hash ^ ct, shadow_subkey);
               pt = (ct ^ aes_keystream(shadow_counter)) & mask;
               shadow_counter[31:0] = shadow_counter[31:0] + 32'd1;
               w.plain_hi = pt[127:64];
               w.plain_lo = pt[63:0];
               w.out_bytes = 5'(n);
               w.hash_hi = shadow_hash[127:64];
               w.hash_lo = shadow_hash[63:0];
               plain_pending.push_back(w);
            end
         end
      endcase
   endfunction

   // Valid stays high after acceptance so that a word with no gap follows at once;
   // it drops when a gap is drawn or when the sender drains.
   task automatic send_word(input logic [1:0] kind, input logic [3:0] slot,
                            input logic [63:0] hi, input logic [63:0] lo, input logic [4:0] count);
      int gap;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_key_index <= slot;
      req_word_hi <= hi;
      req_word_lo <= lo;
      req_byte_count <= count;
      do @(posedge clock); while (!req_ready);
      decrypt_word(kind, slot, {hi, lo}, count);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_KEY_MODE: shadow_mode = value[1:0];
         CSR_HSUB_HI: shadow_subkey[127:64] = value;
         default: shadow_subkey[63:0] = value;
      endcase
      @(posedge clock);
   endtask

   // Waits for the response queue to drain, then lets the engine settle.
   task automatic drain_block();
      req_valid <= 1'b0;
      while (plain_pending.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic load_all_keys();
      for (int k = 0; k < RoundKeySlotsDefault; k++)
         send_word(REQ_LOAD_KEY, 4'(k), rand64(), rand64(), 5'd16);
   endtask

   // Responses: random stalls unless turned off, each checked against the oldest prediction.
   always @(posedge clock) begin
      plain_word_type w;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (plain_pending.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("Unexpected plaintext word at %0t", $realtime);
            end else begin
               w = plain_pending.pop_front();
               if (rsp_plain_hi !== w.plain_hi || rsp_plain_lo !== w.plain_lo ||
                   rsp_out_bytes !== w.out_bytes || rsp_hash_hi !== w.hash_hi ||
                   rsp_hash_lo !== w.hash_lo) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("Mismatch: exp %h %h %0d %h %h got %h %h %0d %h %h",
                              w.plain_hi, w.plain_lo, w.out_bytes, w.hash_hi, w.hash_lo,
                              rsp_plain_hi, rsp_plain_lo, rsp_out_bytes,
                              rsp_hash_hi, rsp_hash_lo);
               end
            end
         end
         rsp_ready <= rsp_stall_off ? 1'b1 : ($urandom_range(0, 7) < 5);
      end
   end

   // Directed: extremes of data and byte count, every load kind, out-of-range key slot,
   // zero and oversized byte counts, and the 32-bit counter wrap.
   task automatic test_directed();
      load_all_keys();
      send_word(REQ_LOAD_KEY, 4'd15, '1, '1, 5'd16);
      send_word(REQ_LOAD_CTR, 4'd0, '1, 64'hffff_ffff_ffff_fffe, 5'd16);
      send_word(REQ_LOAD_HASH, 4'd0, '0, '0, 5'd16);
      send_word(REQ_CIPHER, 4'd0, '0, '0, 5'd16);
      send_word(REQ_CIPHER, 4'd0, '1, '1, 5'd16);
      send_word(REQ_CIPHER, 4'd0, '1, '1, 5'd1);
      send_word(REQ_CIPHER, 4'd0, '1, '1, 5'd15);
      send_word(REQ_CIPHER, 4'd0, rand64(), rand64(), 5'd0);
      send_word(REQ_CIPHER, 4'd0, rand64(), rand64(), 5'd31);
      send_word(REQ_CIPHER, 4'd9, rand64(), rand64(), 5'd17);
      send_word(REQ_LOAD_HASH, 4'd0, '1, '1, 5'd0);
      send_word(REQ_CIPHER, 4'd0, rand64(), rand64(), 5'd8);
      drain_block();
   endtask

   // Random: mostly well-formed streams (counter, an optional hash, blocks that may end in a
   // partial one), with key reloads and stray loads mixed in.
   task automatic test_random_streams(input int words);
      int sent;
      int len;
      logic [4:0] count;
      sent = 0;
      while (sent < words) begin
         if ($urandom_range(0, 9) == 0) begin
            send_word(REQ_LOAD_KEY, 4'($urandom_range(0, 15)), rand64(), rand64(),
                      5'($urandom_range(0, 31)));
            sent++;
         end
         send_word(REQ_LOAD_CTR, 4'($urandom), rand64(), rand64(), 5'($urandom));
         if ($urandom_range(0, 1)) send_word(REQ_LOAD_HASH, 4'($urandom), rand64(), rand64(),
                                             5'($urandom));
         len = $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            count = (i == len - 1 && $urandom_range(0, 1)) ? 5'($urandom_range(0, 31)) : 5'd16;
            send_word(REQ_CIPHER, 4'($urandom), rand64(), rand64(), count);
            sent++;
         end
      end
   endtask

   task automatic test_key_modes();
      logic [1:0] mode_list [4] = '{2'd0, 2'd2, 2'd1, 2'd3};
      foreach (mode_list[m]) begin
         write_csr(CSR_KEY_MODE, {$urandom, 30'd0, mode_list[m]} );
         write_csr(CSR_HSUB_HI, (m == 0) ? '1 : rand64());
         write_csr(CSR_HSUB_LO, (m == 0) ? '1 : (m == 1) ? '0 : rand64());
         test_random_streams(300);
         drain_block();
      end
   endtask

   // Sender holds off until the pipeline is empty, then issues random streams
   // with the response side never stalling.
   task automatic test_hold_off();
      rsp_stall_off = 1'b1;
      drain_block();
      test_random_streams(60);
      drain_block();
      rsp_stall_off = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      shadow_counter = '0;
      shadow_hash = '0;
      shadow_subkey = '0;
      shadow_mode = 2'd0;
      foreach (shadow_keys[k]) shadow_keys[k] = '0;
      test_directed();
      test_key_modes();
      test_hold_off();
      drain_block();
      if (mismatch_count == 0 && plain_pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
